[rtl/command_stream_register_snoop_assert.svh]
// ----------------------------------------------------------------------------
// command stream register snoop assertion macros
// Concurrent assertion wrappers clocked on clk_i, with and without reset gating
// ----------------------------------------------------------------------------
`ifndef COMMAND_STREAM_REGISTER_SNOOP_ASSERT_SVH
`define COMMAND_STREAM_REGISTER_SNOOP_ASSERT_SVH

// check gated off while rst_ni is low
`define CSRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that holds in and out of reset
`define CSRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/csrs_pkg.sv]
// ----------------------------------------------------------------------------
// csrs_pkg
// Types and constants shared by the command stream register snoop
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csrs_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned NUM_TRACKED = 10;
  localparam int unsigned ADDR_W      = 17;
  localparam int unsigned REMAIN_W    = 15;
  localparam int unsigned FMT_CNT_W   = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned FORMAT_SLOT = 0;

  // packed result: status, ten captured words, format write count
  localparam int unsigned OUT_BITS    = STATUS_W + NUM_TRACKED * WORD_W + FMT_CNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned REGS_LSB    = STATUS_W;
  localparam int unsigned FMT_CNT_LSB = STATUS_W + NUM_TRACKED * WORD_W;

  localparam logic [ADDR_W-1:0]    ADDR_STEP   = ADDR_W'(4);
  localparam logic [FMT_CNT_W-1:0] FMT_CNT_MAX = '1;

  // byte addresses of the tracked registers, highest slot first
  localparam logic [NUM_TRACKED-1:0][ADDR_W-1:0] TRACKED_ADDR = {
    17'h043E8, 17'h043B4, 17'h043B0, 17'h043E4, 17'h043E0,
    17'h04288, 17'h04F1C, 17'h04F04, 17'h04F00, 17'h04F10
  };

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_PAY0    = 2'd1,
    MODE_PAY3    = 2'd2,
    MODE_DISCARD = 2'd3
  } parse_mode_e;

  typedef enum logic [1:0] {
    PKT_TYPE0 = 2'd0,
    PKT_TYPE1 = 2'd1,
    PKT_TYPE2 = 2'd2,
    PKT_TYPE3 = 2'd3
  } pkt_type_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ILLEGAL   = 2'd1,
    STATUS_TRUNCATED = 2'd2
  } status_e;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } stream_item_t;

  typedef struct packed {
    status_e                               status;
    logic [NUM_TRACKED-1:0][WORD_W-1:0]    regs;
    logic [FMT_CNT_W-1:0]                  fmt_count;
  } snoop_result_t;

endpackage

[rtl/command_stream_register_snoop.sv]
// Command stream register snoop: takes one 32-bit command dword per cycle on
// the slave stream (tlast marks the last dword of a stream) and reports one
// result transaction at stream end or at the first bad packet, carrying a
// status plus the last values written to ten tracked depth and scissor
// registers and a saturating count of depth format writes. A dword is decoded
// while it sits in the input register, and its result is loaded into the
// result register once that register has room; throughput is one dword per
// cycle, limited only by the single result register when the master side
// stalls. Parser state is updated once per dword with no iteration.
// ----------------------------------------------------------------------------
// command_stream_register_snoop
// Top level: input register, packet parser and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "command_stream_register_snoop_assert.svh"

module command_stream_register_snoop
  import csrs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [WORD_W-1:0]      s_axis_tdata_i,   // [31:0] stream_word
  input  logic                   s_axis_tlast_i,   // last_word
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [1:0] status, [33:2] depth_format_word, [65:34] depth_control_word,
  // [97:66] depth_stencil_control_word, [129:98] bandwidth_control_word,
  // [161:130] plane_eq_config_word, [193:162] scissor_top_left,
  // [225:194] scissor_bottom_right, [257:226] clip_top_left,
  // [289:258] clip_bottom_right, [321:290] screen_door_word,
  // [337:322] format_write_count, [343:338] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  stream_item_t  in_item;
  stream_item_t  stage_item;
  logic          stage_valid;
  logic          out_can_load;
  logic          fire;
  logic          emit;
  snoop_result_t parse_result;
  snoop_result_t out_result;

  assign in_item.word = s_axis_tdata_i;
  assign in_item.last = s_axis_tlast_i;

  // a dword is decoded once the result register has room
  assign fire = stage_valid && out_can_load;

  csrs_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_item_i  (in_item),
    .valid_o    (stage_valid),
    .advance_i  (fire),
    .item_o     (stage_item)
  );

  csrs_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (stage_item),
    .emit_o   (emit),
    .result_o (parse_result)
  );

  csrs_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire && emit),
    .result_i   (parse_result),
    .can_load_o (out_can_load),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .result_o   (out_result)
  );

  // pack the result transaction, lowest field first
  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[STATUS_W-1:0] = out_result.status;
    for (int k = 0; k < NUM_TRACKED; k++) begin
      m_axis_tdata_o[REGS_LSB + k * WORD_W +: WORD_W] = out_result.regs[k];
    end
    m_axis_tdata_o[FMT_CNT_LSB +: FMT_CNT_W] = out_result.fmt_count;
  end

  // error results carry nothing but their status
  `CSRS_ASSERT(a_err_zero, (m_axis_tvalid_o && out_result.status != STATUS_OK) |-> (out_result.regs == '0 && out_result.fmt_count == '0), "error result with nonzero payload")

  // a new result only follows a decoded dword
  `CSRS_ASSERT(a_result_cause, $rose(m_axis_tvalid_o) |-> $past(fire && emit), "result without a decoded dword")

  // padding above the packed fields stays zero
  `CSRS_ASSERT_ALWAYS(a_pad_zero, m_axis_tdata_o[OUT_TDATA_W-1:OUT_BITS] == '0, "nonzero tdata padding")

endmodule

[rtl/csrs_in_stage.sv]
// ----------------------------------------------------------------------------
// csrs_in_stage
// Input register for stream words, refilled in the cycle it is drained
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csrs_in_stage
  import csrs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  stream_item_t in_item_i,
  output logic         valid_o,
  input  logic         advance_i,
  output stream_item_t item_o
);

  logic         valid_q, valid_d;
  stream_item_t item_q;
  logic         load;

  // free slot when empty or being drained this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/csrs_parser.sv]
// ----------------------------------------------------------------------------
// csrs_parser
// Packet header decode, register write tracking and result generation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csrs_parser
  import csrs_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  stream_item_t  item_i,
  output logic          emit_o,
  output snoop_result_t result_o
);

  parse_mode_e                        mode_q, mode_d;
  logic [REMAIN_W-1:0]                remain_q, remain_d;
  logic [ADDR_W-1:0]                  addr_q, addr_d;
  logic [NUM_TRACKED-1:0][WORD_W-1:0] regs_q, regs_d;
  logic [FMT_CNT_W-1:0]               fmt_cnt_q, fmt_cnt_d;

  parse_mode_e                        mode_n;
  logic [REMAIN_W-1:0]                remain_n;
  logic [ADDR_W-1:0]                  addr_n;
  logic [NUM_TRACKED-1:0][WORD_W-1:0] regs_n;
  logic [FMT_CNT_W-1:0]               fmt_cnt_n;
  logic                               clear;
  logic                               emit;
  snoop_result_t                      result;
  pkt_type_e                          pkt_type;

  assign pkt_type = pkt_type_e'(item_i.word[31:30]);

  // next state and result for the word in the input register
  always_comb begin
    mode_n    = mode_q;
    remain_n  = remain_q;
    addr_n    = addr_q;
    regs_n    = regs_q;
    fmt_cnt_n = fmt_cnt_q;
    clear     = 1'b0;
    emit      = 1'b0;
    result    = '0;
    case (mode_q)
      MODE_HEADER: begin
        case (pkt_type)
          PKT_TYPE1: begin
            emit          = 1'b1;
            result.status = STATUS_ILLEGAL;
            if (item_i.last) begin
              clear = 1'b1;
            end else begin
              mode_n = MODE_DISCARD;
            end
          end
          PKT_TYPE2: begin
            if (item_i.last) begin
              emit             = 1'b1;
              result.status    = STATUS_OK;
              result.regs      = regs_q;
              result.fmt_count = fmt_cnt_q;
              clear            = 1'b1;
            end
          end
          default: begin
            if (item_i.last) begin
              emit          = 1'b1;
              result.status = STATUS_TRUNCATED;
              clear         = 1'b1;
            end else begin
              mode_n   = (pkt_type == PKT_TYPE0) ? MODE_PAY0 : MODE_PAY3;
              remain_n = {1'b0, item_i.word[29:16]} + REMAIN_W'(1);
              addr_n   = {2'b00, item_i.word[12:0], 2'b00};
            end
          end
        endcase
      end
      MODE_PAY0, MODE_PAY3: begin
        // register write capture for type-0 payload
        if (mode_q == MODE_PAY0) begin
          for (int k = 0; k < NUM_TRACKED; k++) begin
            if (addr_q == TRACKED_ADDR[k]) begin
              regs_n[k] = item_i.word;
              if (k == FORMAT_SLOT && fmt_cnt_q != FMT_CNT_MAX) begin
                fmt_cnt_n = fmt_cnt_q + FMT_CNT_W'(1);
              end
            end
          end
          addr_n = addr_q + ADDR_STEP;
        end
        if (remain_q != '0) begin
          remain_n = remain_q - REMAIN_W'(1);
        end
        if (remain_n == '0) begin
          mode_n = MODE_HEADER;
        end
        if (item_i.last) begin
          emit  = 1'b1;
          clear = 1'b1;
          if (remain_n == '0) begin
            result.status    = STATUS_OK;
            result.regs      = regs_n;
            result.fmt_count = fmt_cnt_n;
          end else begin
            result.status = STATUS_TRUNCATED;
          end
        end
      end
      default: begin
        if (item_i.last) begin
          clear = 1'b1;
        end
      end
    endcase
  end

  // stream end returns to the reset state; an illegal packet mid-stream discards until then
  always_comb begin
    if (clear) begin
      mode_d    = MODE_HEADER;
      remain_d  = '0;
      addr_d    = '0;
      regs_d    = '0;
      fmt_cnt_d = '0;
    end else begin
      mode_d    = mode_n;
      remain_d  = remain_n;
      addr_d    = addr_n;
      regs_d    = regs_n;
      fmt_cnt_d = fmt_cnt_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_HEADER;
      remain_q  <= '0;
      addr_q    <= '0;
      regs_q    <= '0;
      fmt_cnt_q <= '0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      remain_q  <= remain_d;
      addr_q    <= addr_d;
      regs_q    <= regs_d;
      fmt_cnt_q <= fmt_cnt_d;
    end
  end

  assign emit_o   = emit;
  assign result_o = result;

endmodule

[rtl/csrs_out_stage.sv]
// ----------------------------------------------------------------------------
// csrs_out_stage
// Result register holding one snapshot or error until it is taken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csrs_out_stage
  import csrs_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  snoop_result_t result_i,
  output logic          can_load_o,
  output logic          valid_o,
  input  logic          ready_i,
  output snoop_result_t result_o
);

  logic          valid_q, valid_d;
  snoop_result_t result_q;

  // room when empty or when the held result leaves this cycle
  assign can_load_o = !valid_q || ready_i;
  assign valid_d    = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
